// ===== rtl/vwq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwq_pkg
// Shared codes and types of the voice wait queue.
// ----------------------------------------------------------------------------
package vwq_pkg;

    localparam int CHAN_W   = 8;
    localparam int STATUS_W = 4;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_QUEUED    = 4'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NOPREEMPT = 4'd2;
    localparam logic [STATUS_W-1:0] ST_CANCELLED = 4'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_STARTED   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_TIMEDOUT  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TICKDONE  = 4'd8;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAN_W-1:0]   channel;
        logic                last;
    } res_t;

endpackage

// ===== rtl/vwq_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwq_slot_ram
// Slot store: one synchronous write port and one registered read port.
// ----------------------------------------------------------------------------
module vwq_slot_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data holds while no read is issued, so a stalled walk keeps its slot.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/vwq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vwq_engine
// Command sequencer: ring pointers, valid bits and the slot walk over the RAM.
// ----------------------------------------------------------------------------
module vwq_engine #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIMER_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [vwq_pkg::CMD_W-1:0]      cmd,
    input  logic [vwq_pkg::CHAN_W-1:0]     ch,
    input  logic [15:0]                    tmo,
    input  logic                           pre,
    output vwq_pkg::res_t                  res,
    output logic                           res_valid,
    input  logic                           res_ready,
    output logic                           rd_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
    input  logic [vwq_pkg::CHAN_W+TIMER_BITS-1:0] rd_data,
    output logic                           wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
    output logic [vwq_pkg::CHAN_W+TIMER_BITS-1:0] wr_data
);
    import vwq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = OW + 1;
    localparam int WW = CHAN_W + TIMER_BITS;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WALK    = 3'd1;
    localparam logic [2:0] S_DISP    = 3'd2;
    localparam logic [2:0] S_DISP_RD = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    logic [2:0]             state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [CHAN_W-1:0]      ch_reg, ch_next;
    logic [PW-1:0]          head_reg, head_next;
    logic [PW-1:0]          tail_reg, tail_next;
    logic [OW-1:0]          occ_reg, occ_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [OW-1:0]          idx_reg, idx_next;
    logic [PW-1:0]          addr_reg, addr_next;
    logic                   p_valid_reg, p_valid_next;
    logic [PW-1:0]          p_addr_reg, p_addr_next;
    logic                   found_reg, found_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic [CHAN_W-1:0]      ram_ch;
    logic [TIMER_BITS-1:0]  ram_t;
    logic [TIMER_BITS-1:0]  t_dec;
    logic                   slot_live;
    logic                   need_emit;
    logic                   stage_done;
    logic                   advance;

    assign ram_ch    = rd_data[WW-1:TIMER_BITS];
    assign ram_t     = rd_data[TIMER_BITS-1:0];
    assign t_dec     = (ram_t != '0) ? ram_t - 1'b1 : '0;
    assign slot_live = valid_reg[p_addr_reg];
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        ch_next      = ch_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        addr_next    = addr_reg;
        p_valid_next = p_valid_reg;
        p_addr_next  = p_addr_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        rd_addr      = addr_reg;
        wr_en        = 1'b0;
        wr_addr      = p_addr_reg;
        wr_data      = {ram_ch, t_dec};
        res_valid    = 1'b0;
        res          = '{status: status_reg, channel: '0, last: 1'b1};
        need_emit    = 1'b0;
        stage_done   = 1'b0;
        advance      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next = cmd;
                    ch_next  = ch;
                    unique case (cmd)
                        CMD_ENQUEUE:
                        begin
                            state_next = S_EMIT;
                            if (occ_reg >= OW'(QUEUE_DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (!pre)
                            begin
                                status_next = ST_NOPREEMPT;
                            end
                            else
                            begin
                                status_next          = ST_QUEUED;
                                wr_en                = 1'b1;
                                wr_addr              = tail_reg;
                                wr_data              = {ch, TIMER_BITS'(tmo)};
                                valid_next[tail_reg] = 1'b1;
                                tail_next            = ptr_inc(tail_reg);
                                occ_next             = occ_reg + 1'b1;
                            end
                        end
                        CMD_CANCEL, CMD_TICK:
                        begin
                            idx_next     = '0;
                            addr_next    = head_reg;
                            p_valid_next = 1'b0;
                            found_next   = 1'b0;
                            state_next   = S_WALK;
                        end
                        CMD_DISPATCH:
                        begin
                            state_next = S_DISP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // Stage two works on the slot already fetched while stage one
                // fetches the next one; a pending timeout stalls both.
                need_emit  = p_valid_reg && (cmd_reg == CMD_TICK) && slot_live
                             && (t_dec == '0);
                stage_done = p_valid_reg && (!need_emit || res_ready);
                res_valid  = need_emit;
                res        = '{status: ST_TIMEDOUT, channel: ram_ch, last: 1'b0};
                if (stage_done && slot_live)
                begin
                    if (cmd_reg == CMD_TICK)
                    begin
                        wr_en = 1'b1;
                        if (t_dec == '0)
                        begin
                            valid_next[p_addr_reg] = 1'b0;
                        end
                    end
                    else if (ram_ch == ch_reg)
                    begin
                        valid_next[p_addr_reg] = 1'b0;
                        found_next             = 1'b1;
                    end
                end
                advance = !p_valid_reg || stage_done;
                if (advance)
                begin
                    if (idx_reg < occ_reg)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = addr_reg;
                        p_addr_next  = addr_reg;
                        p_valid_next = 1'b1;
                        addr_next    = ptr_inc(addr_reg);
                        idx_next     = idx_reg + 1'b1;
                    end
                    else
                    begin
                        p_valid_next = 1'b0;
                        state_next   = S_EMIT;
                        if (cmd_reg == CMD_TICK)
                        begin
                            status_next = ST_TICKDONE;
                        end
                        else
                        begin
                            status_next = found_next ? ST_CANCELLED : ST_NOTFOUND;
                        end
                    end
                end
            end
            S_DISP:
            begin
                // One slot leaves the head per cycle; holes are dropped on the way.
                if (occ_reg == '0)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_EMIT;
                end
                else
                begin
                    head_next = ptr_inc(head_reg);
                    occ_next  = occ_reg - 1'b1;
                    if (valid_reg[head_reg])
                    begin
                        valid_next[head_reg] = 1'b0;
                        rd_en                = 1'b1;
                        rd_addr              = head_reg;
                        state_next           = S_DISP_RD;
                    end
                end
            end
            S_DISP_RD:
            begin
                res_valid = 1'b1;
                res       = '{status: ST_STARTED, channel: ram_ch, last: 1'b1};
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            valid_reg   <= '0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            valid_reg   <= valid_next;
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ch_reg     <= ch_next;
        idx_reg    <= idx_next;
        addr_reg   <= addr_next;
        p_addr_reg <= p_addr_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    logic [SW-1:0] ring_sum;
    logic [SW-1:0] ring_end;

    assign ring_sum = SW'(head_reg) + SW'(occ_reg);
    assign ring_end = (ring_sum >= SW'(QUEUE_DEPTH)) ? ring_sum - SW'(QUEUE_DEPTH) : ring_sum;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ring_end == SW'(tail_reg))
        else $error("tail does not equal head plus occupancy");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("pending result changed while stalled");

    a_enqueue_grows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (cmd == CMD_ENQUEUE) && pre
        && (occ_reg < OW'(QUEUE_DEPTH))
        |=> (occ_reg == $past(occ_reg) + 1'b1) && valid_reg[$past(tail_reg)])
        else $error("accepted enqueue did not fill the tail slot");

endmodule

// ===== rtl/voice_wait_queue_with_timeout.sv =====
`timescale 1ns / 1ps
// Enqueue writes its slot as the command is accepted. Dispatch drops holes at the head
// and reads the first waiting slot. Cancel and tick walk every occupied slot, reading one RAM
// entry per cycle unless a timeout result is held back by the output side. One item is in
// work at a time; the next is taken once the final result sits in the output register.
// Reset clears pointers, occupancy and valid bits at once; the slot RAM is not cleared and
// needs no clearing pass.
// ----------------------------------------------------------------------------
// voice_wait_queue_with_timeout
// Circular wait queue of voice channels with per-slot timeout countdown.
// ----------------------------------------------------------------------------
module voice_wait_queue_with_timeout #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIMER_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // channel[7:0], timeout[23:8], preempt_ok[24], zero
    input  logic [1:0]  s_tuser,   // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_channel[7:0]
    output logic [3:0]  m_tuser,   // status[3:0]
    output logic        m_tlast
);
    import vwq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int WW = CHAN_W + TIMER_BITS;

    res_t          res;
    logic          res_valid;
    logic          res_ready;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [WW-1:0] rd_data;
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    logic          out_valid_reg;
    res_t          out_res_reg;

    vwq_engine #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIMER_BITS  (TIMER_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .cmd       (s_tuser),
        .ch        (s_tdata[7:0]),
        .tmo       (s_tdata[23:8]),
        .pre       (s_tdata[24]),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    vwq_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WW)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register: the engine moves on as soon as its result is parked here.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg.channel;
    assign m_tuser  = out_res_reg.status;
    assign m_tlast  = out_res_reg.last;

endmodule

// ===== test/tb_voice_wait_queue_with_timeout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voice_wait_queue_with_timeout
// Self-checking bench for the voice wait queue. A scoreboard class keeps its
// own copy of the slot array and pointers. It predicts the status items for
// every accepted command and compares them in order with what the block
// returns. Directed commands cover the corner cases. Random phases then fill
// the queue, drain it, run down timers and mix commands, with random stalls
// on both sides.
// ----------------------------------------------------------------------------
module tb_voice_wait_queue_with_timeout;

    import vwq_pkg::*;

    localparam int SLOTS = 32;

    class queue_scoreboard;
        logic [7:0]  slot_chan [SLOTS];
        logic        slot_live [SLOTS];
        logic [15:0] slot_left [SLOTS];
        logic [4:0]  head_idx;
        logic [4:0]  tail_idx;
        int unsigned fill;
        res_t        expected_q[$];
        int unsigned mismatches;

        function new();
            head_idx   = '0;
            tail_idx   = '0;
            fill       = 0;
            mismatches = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_chan[i] = '0;
                slot_live[i] = 1'b0;
                slot_left[i] = '0;
            end
        endfunction

        function void push_status(logic [3:0] st, logic [7:0] ch, logic lst);
            res_t r;
            r.status  = st;
            r.channel = ch;
            r.last    = lst;
            expected_q.push_back(r);
        endfunction

        // Works out the status items for one accepted command and updates the queue copy.
        function void note_request(logic [1:0] cmd, logic [7:0] ch, logic [15:0] tmo,
                                   logic pre);
            logic [4:0] a;
            bit         hit;
            bit         started;
            case (cmd)
                CMD_ENQUEUE:
                begin
                    // The full check has priority over the preemption check.
                    if (fill >= SLOTS)
                        push_status(ST_FULL, 8'd0, 1'b1);
                    else if (!pre)
                        push_status(ST_NOPREEMPT, 8'd0, 1'b1);
                    else
                    begin
                        slot_chan[tail_idx] = ch;
                        slot_left[tail_idx] = tmo;
                        slot_live[tail_idx] = 1'b1;
                        tail_idx = tail_idx + 5'd1;
                        fill++;
                        push_status(ST_QUEUED, 8'd0, 1'b1);
                    end
                end
                CMD_CANCEL:
                begin
                    hit = 1'b0;
                    for (int unsigned i = 0; i < fill; i++)
                    begin
                        a = head_idx + 5'(i);
                        if (slot_live[a] && slot_chan[a] == ch)
                        begin
                            slot_live[a] = 1'b0;
                            hit = 1'b1;
                        end
                    end
                    push_status(hit ? ST_CANCELLED : ST_NOTFOUND, 8'd0, 1'b1);
                end
                CMD_DISPATCH:
                begin
                    // Holes at the head are dropped on the way to the first waiting channel.
                    started = 1'b0;
                    while (fill != 0 && !started)
                    begin
                        a = head_idx;
                        head_idx = head_idx + 5'd1;
                        fill--;
                        if (slot_live[a])
                        begin
                            slot_live[a] = 1'b0;
                            push_status(ST_STARTED, slot_chan[a], 1'b1);
                            started = 1'b1;
                        end
                    end
                    if (!started)
                        push_status(ST_EMPTY, 8'd0, 1'b1);
                end
                CMD_TICK:
                begin
                    for (int unsigned i = 0; i < fill; i++)
                    begin
                        a = head_idx + 5'(i);
                        if (slot_live[a])
                        begin
                            if (slot_left[a] != 0)
                                slot_left[a] = slot_left[a] - 16'd1;
                            if (slot_left[a] == 0)
                            begin
                                slot_live[a] = 1'b0;
                                push_status(ST_TIMEDOUT, slot_chan[a], 1'b0);
                            end
                        end
                    end
                    push_status(ST_TICKDONE, 8'd0, 1'b1);
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_result(logic [3:0] st, logic [7:0] ch, logic lst);
            res_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item status %0d channel %0d last %0d",
                                          st, ch, lst));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
            if (ch !== want.channel)
                report_mismatch($sformatf("channel %0d, expected %0d (status %0d)",
                                          ch, want.channel, want.status));
            if (lst !== want.last)
                report_mismatch($sformatf("last %0d, expected %0d (status %0d)",
                                          lst, want.last, want.status));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    queue_scoreboard sb = new();
    bit              idle_on  = 1'b1;
    bit              hold_req = 1'b0;
    logic [7:0]      chan_pool [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h3C, 8'hA5, 8'h7F, 8'h42};

    voice_wait_queue_with_timeout i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Offers one command item and waits until the block takes it.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [15:0] tmo, input logic pre);
        while (idle_on && $urandom_range(99) < 35)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {7'd0, pre, tmo, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, ch, tmo, pre);
        @(negedge clk);
    endtask

    // Result side: checks at the rising edge, moves ready at the falling edge.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata, m_tlast);
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = !(idle_on && $urandom_range(99) < 35);
        end
    end

    initial
    begin
        int unsigned phase;
        int unsigned roll;
        int unsigned enq_lim;
        int unsigned can_lim;
        int unsigned dis_lim;
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [15:0] tmo;
        logic        pre;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ENQUEUE;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty queue, rejected enqueue, both timer extremes, duplicate channels,
        // holes left by timeouts and cancel, then dispatch across those holes.
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 1'b1);
        send_item(CMD_TICK,     8'hFF, 16'hFFFF, 1'b0);
        send_item(CMD_CANCEL,   8'h12, 16'h0000, 1'b1);
        send_item(CMD_ENQUEUE,  8'hFF, 16'hFFFF, 1'b0);
        send_item(CMD_ENQUEUE,  8'h00, 16'h0000, 1'b1);
        send_item(CMD_ENQUEUE,  8'hFF, 16'hFFFF, 1'b1);
        send_item(CMD_ENQUEUE,  8'h5A, 16'h0001, 1'b1);
        send_item(CMD_ENQUEUE,  8'h00, 16'h0002, 1'b1);
        send_item(CMD_ENQUEUE,  8'h5A, 16'h0003, 1'b1);
        send_item(CMD_TICK,     8'h00, 16'h0000, 1'b0);
        send_item(CMD_CANCEL,   8'h00, 16'h0000, 1'b0);
        send_item(CMD_CANCEL,   8'h00, 16'hAAAA, 1'b1);
        send_item(CMD_ENQUEUE,  8'h07, 16'h5555, 1'b1);
        send_item(CMD_DISPATCH, 8'hFF, 16'h0000, 1'b0);
        send_item(CMD_TICK,     8'h00, 16'h0000, 1'b1);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 1'b1);
        send_item(CMD_CANCEL,   8'hFF, 16'h0000, 1'b1);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 1'b1);
        send_item(CMD_DISPATCH, 8'h00, 16'h0000, 1'b1);
        send_item(CMD_TICK,     8'h00, 16'h0000, 1'b1);

        // Phases of forty items: fill, drain, timer run-down, mixed.
        for (int unsigned k = 0; k < 440; k++)
        begin
            phase = (k / 40) % 4;
            case (phase)
                0: begin enq_lim = 70; can_lim = 80; dis_lim = 90; end
                1: begin enq_lim = 20; can_lim = 40; dis_lim = 90; end
                2: begin enq_lim = 40; can_lim = 50; dis_lim = 60; end
                default: begin enq_lim = 25; can_lim = 50; dis_lim = 75; end
            endcase
            roll = $urandom_range(99);
            if (roll < enq_lim)
                cmd = CMD_ENQUEUE;
            else if (roll < can_lim)
                cmd = CMD_CANCEL;
            else if (roll < dis_lim)
                cmd = CMD_DISPATCH;
            else
                cmd = CMD_TICK;
            // A small channel pool makes cancels hit and duplicates common.
            if ($urandom_range(99) < 75)
                ch = chan_pool[$urandom_range(7)];
            else
                ch = 8'($urandom_range(255));
            if ($urandom_range(99) < 70)
                tmo = 16'($urandom_range(6));
            else
                tmo = 16'($urandom_range(65535));
            pre = ($urandom_range(99) < 85);
            idle_on = !(k >= 200 && k < 300);
            if (k == 100)
                hold_req = 1'b1;
            send_item(cmd, ch, tmo, pre);
        end
        s_tvalid = 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
